@@ src/ole_pkg.sv @@
// Package: shared types and constants for the ordered list engine.
package ole_pkg;
    localparam int Capacity   = 256;
    localparam int SlotW      = $clog2(Capacity);
    localparam int CountW     = SlotW + 1;
    localparam int ValueW     = 32;
    localparam int LinkW      = 2 * SlotW + 2;

    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_VAL   = 3'd3,
        FN_DEL_FRONT = 3'd4,
        FN_DEL_BACK  = 3'd5,
        FN_FIND      = 3'd6,
        FN_BAD       = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic             has_prev;
        logic             has_next;
        logic [SlotW-1:0] prev;
        logic [SlotW-1:0] next;
    } link_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,   // read slot under cursor
        S_WALK_CHK,  // data back, compare / advance
        S_INS_NEW,   // write new entry and its own link
        S_INS_NEXT,  // queue second neighbor patch (middle insert)
        S_DROP_RD,   // read link of victim
        S_DROP_LNK,  // victim link back, patch prev neighbor
        S_DROP_NEXT, // patch next neighbor
        S_DROP_CNT,  // shrink count
        S_LAST_RD,   // read highest occupied slot
        S_LAST_DAT,  // its entry and link arrive
        S_MOVE_WR,   // move it into the freed slot, patch its prev
        S_MOVE_NEXT, // patch its next
        S_PATCH_RD,  // neighbor link read
        S_PATCH_WR,  // neighbor link modify and write back
        S_DONE
    } state_t;
endpackage

@@ src/ordered_list_engine.sv @@
// Top level: linked-list engine kept in entry and link RAMs.
//
// Usage:
//   Input channel (s_valid/s_ready) carries one word: s_func, s_value,
//   s_position. Each accepted word yields exactly one result word on the
//   m_ channel: m_status and m_length (entry count after the operation).
//   One word is processed at a time; s_ready is high only while idle with
//   the result register empty.
// Steps, k = entries visited: a refused or unknown func goes straight
//   to the result; insert into an empty list writes the entry only;
//   insert at front/back adds one link read-modify-write; insert at
//   position p inside the list walks to entry p first; find walks k
//   entries; delete front/back unlinks the victim and may move the top
//   entry into its slot; delete value walks k entries, then deletes alike.
//   Each walk step is a RAM read plus a compare, serial through the link RAM.
// Next word: taken only once the result is accepted and s_ready returns.
// Reset: aresetn (synchronous, active low) empties the list. RAM
//   contents are not cleared; only occupied slots are ever read.
// Stall: a held result sits in the output register; the next word is
//   not taken until that result is accepted.
module ordered_list_engine (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [2:0]                       s_func,
    input  logic signed [ole_pkg::ValueW-1:0] s_value,
    input  logic [ole_pkg::CountW-1:0]       s_position,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [ole_pkg::CountW-1:0]       m_length
);
    import ole_pkg::*;

    state_t state_reg, state_next;

    logic [CountW-1:0] count_reg, count_next;
    logic [SlotW-1:0]  front_reg, front_next;
    logic [SlotW-1:0]  back_reg, back_next;

    // latched request
    func_t             func_reg, func_next;
    logic [ValueW-1:0] value_reg, value_next;
    logic [CountW-1:0] pos_reg, pos_next;

    // walk cursor and step counter
    logic [SlotW-1:0]  cur_reg, cur_next;
    logic [CountW-1:0] step_reg, step_next;

    // victim / moved-entry bookkeeping
    logic [SlotW-1:0]  vic_reg, vic_next;
    link_t             lnk_reg, lnk_next;
    logic [ValueW-1:0] mval_reg, mval_next;

    // pending neighbor patch: slot, side (1 = next side), flag, pointer
    logic [SlotW-1:0]  pa_reg, pa_next;
    logic              pside_reg, pside_next;
    logic              ph_reg, ph_next;
    logic [SlotW-1:0]  px_reg, px_next;
    state_t            ret_reg, ret_next;

    logic              mvalid_reg, mvalid_next;
    status_t           mstat_reg, mstat_next;
    logic [CountW-1:0] mlen_reg, mlen_next;

    // RAM ports
    logic              e_we, l_we;
    logic [SlotW-1:0]  e_addr, l_addr;
    logic [ValueW-1:0] e_wdata, e_rdata;
    link_t             l_wdata, l_rdata;
    logic [LinkW-1:0]  l_rdata_raw;

    logic              take;
    logic [SlotW-1:0]  new_slot;
    logic [SlotW-1:0]  last_slot;
    logic              full;
    logic              empty;
    func_t             s_fn;
    logic              pos_over;
    logic              pos_mid;
    logic              hit;
    logic              ins_front;
    logic              ins_back;

    ole_ram #(.Width(ValueW), .Depth(Capacity)) u_entry_ram (
        .aclk(aclk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
    );
    ole_ram #(.Width(LinkW), .Depth(Capacity)) u_link_ram (
        .aclk(aclk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata_raw)
    );
    assign l_rdata = link_t'(l_rdata_raw);

    assign s_ready   = (state_reg == S_IDLE) && !mvalid_reg;
    assign take      = s_valid && s_ready;
    // new entries go to slot count; highest occupied slot is count-1
    assign new_slot  = count_reg[SlotW-1:0];
    assign last_slot = count_reg[SlotW-1:0] - SlotW'(1);
    assign full      = (count_reg == CountW'(Capacity));
    assign empty     = (count_reg == '0);
    assign s_fn      = func_t'(s_func);
    assign pos_over  = (s_position > count_reg);
    assign pos_mid   = !empty && (s_position != '0) && (s_position < count_reg);
    assign hit       = (e_rdata == value_reg);
    assign ins_front = (func_reg == FN_INS_FRONT) ||
                       ((func_reg == FN_INS_POS) && (pos_reg == '0));
    assign ins_back  = (func_reg == FN_INS_BACK) ||
                       ((func_reg == FN_INS_POS) && (pos_reg >= count_reg));

    assign m_valid  = mvalid_reg;
    assign m_status = mstat_reg;
    assign m_length = mlen_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            front_reg  <= '0;
            back_reg   <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            front_reg  <= front_next;
            back_reg   <= back_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        value_reg <= value_next;
        pos_reg   <= pos_next;
        cur_reg   <= cur_next;
        step_reg  <= step_next;
        vic_reg   <= vic_next;
        lnk_reg   <= lnk_next;
        mval_reg  <= mval_next;
        pa_reg    <= pa_next;
        pside_reg <= pside_next;
        ph_reg    <= ph_next;
        px_reg    <= px_next;
        ret_reg   <= ret_next;
        mstat_reg <= mstat_next;
        mlen_reg  <= mlen_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    case (s_fn)
                        FN_INS_FRONT, FN_INS_BACK: begin
                            state_next = full ? S_DONE : S_INS_NEW;
                        end
                        FN_INS_POS: begin
                            if (full || pos_over) begin
                                state_next = S_DONE;
                            end else if (pos_mid) begin
                                state_next = S_WALK_RD;
                            end else begin
                                state_next = S_INS_NEW;
                            end
                        end
                        FN_DEL_VAL, FN_FIND: begin
                            state_next = empty ? S_DONE : S_WALK_RD;
                        end
                        FN_DEL_FRONT, FN_DEL_BACK: begin
                            state_next = empty ? S_DONE : S_DROP_RD;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_WALK_RD:  state_next = S_WALK_CHK;
            S_WALK_CHK: begin
                if (func_reg == FN_INS_POS) begin
                    state_next = (step_reg == pos_reg) ? S_INS_NEW : S_WALK_RD;
                end else if (hit) begin
                    state_next = (func_reg == FN_FIND) ? S_DONE : S_DROP_RD;
                end else if (step_reg == count_reg) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_WALK_RD;
                end
            end
            S_INS_NEW:   state_next = empty ? S_DONE : S_PATCH_RD;
            S_INS_NEXT:  state_next = S_PATCH_RD;
            S_DROP_RD:   state_next = S_DROP_LNK;
            S_DROP_LNK:  state_next = l_rdata.has_prev ? S_PATCH_RD : S_DROP_NEXT;
            S_DROP_NEXT: state_next = lnk_reg.has_next ? S_PATCH_RD : S_DROP_CNT;
            S_DROP_CNT: begin
                // victim in the top slot (or last entry gone): nothing to move
                state_next = (count_reg == CountW'(1) || vic_reg == last_slot)
                             ? S_DONE : S_LAST_RD;
            end
            S_LAST_RD:   state_next = S_LAST_DAT;
            S_LAST_DAT:  state_next = S_MOVE_WR;
            S_MOVE_WR:   state_next = lnk_reg.has_prev ? S_PATCH_RD : S_MOVE_NEXT;
            S_MOVE_NEXT: state_next = lnk_reg.has_next ? S_PATCH_RD : S_DONE;
            S_PATCH_RD:  state_next = S_PATCH_WR;
            S_PATCH_WR:  state_next = ret_reg;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        step_next   = step_reg;
        vic_next    = vic_reg;
        lnk_next    = lnk_reg;
        mval_next   = mval_reg;
        pa_next     = pa_reg;
        pside_next  = pside_reg;
        ph_next     = ph_reg;
        px_next     = px_reg;
        ret_next    = ret_reg;
        mstat_next  = mstat_reg;
        mlen_next   = mlen_reg;
        mvalid_next = mvalid_reg && !m_ready;
        e_we    = 1'b0;
        l_we    = 1'b0;
        e_addr  = cur_reg;
        l_addr  = cur_reg;
        e_wdata = value_reg;
        l_wdata = '0;
        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    func_next  = s_fn;
                    value_next = s_value;
                    pos_next   = s_position;
                    cur_next   = front_reg;
                    step_next  = CountW'(1);
                    mstat_next = ST_OK;
                    case (s_fn)
                        FN_INS_FRONT, FN_INS_BACK: begin
                            if (full) mstat_next = ST_FULL;
                        end
                        FN_INS_POS: begin
                            if (full) mstat_next = ST_FULL;
                            else if (pos_over) mstat_next = ST_RANGE;
                        end
                        FN_DEL_VAL, FN_FIND, FN_DEL_FRONT, FN_DEL_BACK: begin
                            if (empty) mstat_next = ST_MISS;
                        end
                        default: mstat_next = ST_RANGE;
                    endcase
                    if (s_fn == FN_DEL_FRONT) vic_next = front_reg;
                    else vic_next = back_reg;
                end
            end
            S_WALK_RD: begin
                e_addr = cur_reg;
                l_addr = cur_reg;
            end
            S_WALK_CHK: begin
                if (func_reg == FN_INS_POS) begin
                    if (step_reg != pos_reg) begin
                        cur_next  = l_rdata.next;
                        step_next = step_reg + CountW'(1);
                    end else begin
                        lnk_next = l_rdata; // cur is the insert-after node
                    end
                end else if (hit) begin
                    vic_next = cur_reg;
                end else if (step_reg == count_reg) begin
                    mstat_next = ST_MISS;
                end else begin
                    cur_next  = l_rdata.next;
                    step_next = step_reg + CountW'(1);
                end
            end
            S_INS_NEW: begin
                e_we       = 1'b1;
                e_addr     = new_slot;
                e_wdata    = value_reg;
                l_we       = 1'b1;
                l_addr     = new_slot;
                l_wdata    = '0;
                count_next = count_reg + CountW'(1);
                ph_next    = 1'b1;
                px_next    = new_slot;
                ret_next   = S_DONE;
                if (empty) begin
                    front_next = new_slot;
                    back_next  = new_slot;
                end else if (ins_front) begin
                    l_wdata.has_next = 1'b1;
                    l_wdata.next     = front_reg;
                    pa_next          = front_reg;
                    pside_next       = 1'b0;
                    front_next       = new_slot;
                end else if (ins_back) begin
                    l_wdata.has_prev = 1'b1;
                    l_wdata.prev     = back_reg;
                    pa_next          = back_reg;
                    pside_next       = 1'b1;
                    back_next        = new_slot;
                end else begin
                    l_wdata.has_prev = 1'b1;
                    l_wdata.prev     = cur_reg;
                    l_wdata.has_next = 1'b1;
                    l_wdata.next     = lnk_reg.next;
                    pa_next          = cur_reg;
                    pside_next       = 1'b1;
                    ret_next         = S_INS_NEXT;
                end
            end
            S_INS_NEXT: begin
                // old successor now points back at the new slot (still in px)
                pa_next    = lnk_reg.next;
                pside_next = 1'b0;
                ph_next    = 1'b1;
                ret_next   = S_DONE;
            end
            S_DROP_RD: begin
                l_addr = vic_reg;
                e_addr = vic_reg;
            end
            S_DROP_LNK: begin
                lnk_next = l_rdata;
                if (l_rdata.has_prev) begin
                    pa_next    = l_rdata.prev;
                    pside_next = 1'b1;
                    ph_next    = l_rdata.has_next;
                    px_next    = l_rdata.next;
                    ret_next   = S_DROP_NEXT;
                end else begin
                    front_next = l_rdata.next;
                end
            end
            S_DROP_NEXT: begin
                if (lnk_reg.has_next) begin
                    pa_next    = lnk_reg.next;
                    pside_next = 1'b0;
                    ph_next    = lnk_reg.has_prev;
                    px_next    = lnk_reg.prev;
                    ret_next   = S_DROP_CNT;
                end else begin
                    back_next = lnk_reg.prev;
                end
            end
            S_DROP_CNT: begin
                count_next = count_reg - CountW'(1);
                if (count_reg == CountW'(1)) begin
                    front_next = '0;
                    back_next  = '0;
                end
            end
            S_LAST_RD: begin
                // count already decremented: slot count is the top entry
                l_addr = new_slot;
                e_addr = new_slot;
            end
            S_LAST_DAT: begin
                lnk_next  = l_rdata;
                mval_next = e_rdata;
            end
            S_MOVE_WR: begin
                e_we    = 1'b1;
                e_addr  = vic_reg;
                e_wdata = mval_reg;
                l_we    = 1'b1;
                l_addr  = vic_reg;
                l_wdata = lnk_reg;
                if (lnk_reg.has_prev) begin
                    pa_next    = lnk_reg.prev;
                    pside_next = 1'b1;
                    ph_next    = 1'b1;
                    px_next    = vic_reg;
                    ret_next   = S_MOVE_NEXT;
                end else begin
                    front_next = vic_reg;
                end
            end
            S_MOVE_NEXT: begin
                if (lnk_reg.has_next) begin
                    pa_next    = lnk_reg.next;
                    pside_next = 1'b0;
                    ph_next    = 1'b1;
                    px_next    = vic_reg;
                    ret_next   = S_DONE;
                end else begin
                    back_next = vic_reg;
                end
            end
            S_PATCH_RD: begin
                l_addr = pa_reg;
            end
            S_PATCH_WR: begin
                l_we    = 1'b1;
                l_addr  = pa_reg;
                l_wdata = l_rdata;
                if (pside_reg) begin
                    l_wdata.has_next = ph_reg;
                    l_wdata.next     = px_reg;
                end else begin
                    l_wdata.has_prev = ph_reg;
                    l_wdata.prev     = px_reg;
                end
            end
            S_DONE: begin
                mvalid_next = 1'b1;
                mlen_next   = count_reg;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_length));
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountW'(Capacity));
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid);
    a_len_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_length == count_reg);
`endif

endmodule

@@ src/ole_ram.sv @@
// Generic single-port RAM with registered read.
module ole_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ dv/tb.sv @@
// Testbench for the ordered list engine: random list operations checked against a model list.
`timescale 1ns / 100ps

module tb;
    import ole_pkg::*;

    class list_scoreboard;
        logic [31:0] entries[$];
        logic [1:0]  exp_status[$];
        logic [8:0]  exp_length[$];
        int          errors;

        // apply one operation to the model list and queue its result
        function void note_word(func_t fn, logic [31:0] v, logic [8:0] pos);
            status_t st;
            int      idx;
            st  = ST_OK;
            idx = -1;
            case (fn)
                FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
                    if (entries.size() >= Capacity) st = ST_FULL;
                    else if (fn == FN_INS_FRONT) entries.push_front(v);
                    else if (fn == FN_INS_BACK) entries.push_back(v);
                    else if (pos > entries.size()) st = ST_RANGE;
                    else entries.insert(pos, v);
                end
                FN_DEL_VAL, FN_FIND: begin
                    foreach (entries[i]) if (idx < 0 && entries[i] == v) idx = i;
                    if (idx < 0) st = ST_MISS;
                    else if (fn == FN_DEL_VAL) entries.delete(idx);
                end
                FN_DEL_FRONT: begin
                    if (entries.size() == 0) st = ST_MISS;
                    else void'(entries.pop_front());
                end
                FN_DEL_BACK: begin
                    if (entries.size() == 0) st = ST_MISS;
                    else void'(entries.pop_back());
                end
                default: st = ST_RANGE;
            endcase
            exp_status.push_back(st);
            exp_length.push_back(9'(entries.size()));
        endfunction

        function void check_word(logic [1:0] st, logic [8:0] len);
            logic [1:0] es;
            logic [8:0] el;
            if (exp_status.size() == 0) begin
                report_mismatch("result with nothing expected");
                return;
            end
            es = exp_status.pop_front();
            el = exp_length.pop_front();
            if (st !== es) report_mismatch($sformatf("status %0d want %0d", st, es));
            if (len !== el) report_mismatch($sformatf("length %0d want %0d", len, el));
        endfunction

        function void report_mismatch(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [2:0]        s_func;
    logic signed [31:0] s_value;
    logic [8:0]        s_position;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_status;
    logic [8:0]        m_length;

    list_scoreboard sb;
    bit             calm;       // no idling in the final stretch
    bit             hold_sink;  // long receiver hold-off
    int unsigned    cycles;

    ordered_list_engine u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: fails the run once the cycle counter passes its limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4_000_000) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: sample at rising edge, ready changes at falling edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_word(m_status, m_length);
    end

    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_sink) begin
                m_ready = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 3);
                m_ready = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // offer one word and wait until it is taken; valid drops only for idling
    task automatic send_word(func_t fn, logic [31:0] v, logic [8:0] pos);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= fn;
        s_value    <= v;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(fn, v, pos);
        @(negedge aclk);
    endtask

    // value drawn mostly from a small pool so finds and deletes hit
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    task automatic random_word(int grow_bias);
        func_t       fn;
        int          r;
        logic [8:0]  pos;
        int          len;
        len = sb.entries.size();
        r = $urandom_range(0, 99);
        if (r < grow_bias) fn = func_t'($urandom_range(0, 2));
        else if (r < 97) fn = func_t'($urandom_range(3, 6));
        else fn = FN_BAD;
        // most positions legal; a few beyond the length
        if ($urandom_range(0, 9) == 0) pos = 9'($urandom_range(0, 511));
        else pos = 9'($urandom_range(0, len));
        send_word(fn, pick_value(), pos);
    endtask

    initial begin
        sb         = new();
        calm       = 1'b0;
        hold_sink  = 1'b0;
        cycles     = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_func     = FN_INS_FRONT;
        s_value    = '0;
        s_position = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty-list cases, extremes, every operation
        send_word(FN_DEL_FRONT, 32'd0, 9'd0);
        send_word(FN_DEL_BACK, 32'd0, 9'd0);
        send_word(FN_DEL_VAL, 32'd5, 9'd0);
        send_word(FN_FIND, 32'd5, 9'd0);
        send_word(FN_INS_POS, 32'd1, 9'd1);
        send_word(FN_INS_POS, 32'h8000_0000, 9'd0);
        send_word(FN_INS_FRONT, 32'h7fff_ffff, 9'd0);
        send_word(FN_INS_BACK, 32'hffff_ffff, 9'h1ff);
        send_word(FN_INS_POS, 32'd7, 9'd3);
        send_word(FN_INS_POS, 32'd8, 9'd2);
        send_word(FN_INS_POS, 32'd9, 9'd9);
        send_word(FN_FIND, 32'd7, 9'd0);
        send_word(FN_FIND, 32'h8000_0000, 9'd0);
        send_word(FN_DEL_VAL, 32'h7fff_ffff, 9'd0);
        send_word(FN_DEL_VAL, 32'd8, 9'd0);
        send_word(FN_BAD, 32'd0, 9'd0);
        send_word(FN_DEL_FRONT, 32'd0, 9'd0);
        send_word(FN_DEL_BACK, 32'd0, 9'd0);

        // fill to capacity with a stalled receiver so input backs up
        fork
            begin
                hold_sink = 1'b1;
                repeat (300) @(posedge aclk);
                hold_sink = 1'b0;
            end
        join_none
        while (sb.entries.size() < Capacity)
            send_word(func_t'($urandom_range(0, 2)), $urandom, 9'd0);
        send_word(FN_INS_FRONT, 32'd1, 9'd0);
        send_word(FN_INS_BACK, 32'd1, 9'd0);
        send_word(FN_INS_POS, 32'd1, 9'h1ff);
        send_word(FN_INS_POS, 32'd1, 9'd256);
        send_word(FN_FIND, 32'h1234_5679, 9'd0);
        repeat (200) random_word(30);
        while (sb.entries.size() > 0) send_word(FN_DEL_BACK, 32'd0, 9'd0);

        // random: mostly short lists, balanced churn
        repeat (700) random_word(sb.entries.size() < 20 ? 60 : 45);
        calm = 1'b1;
        repeat (100) random_word(50);
        s_valid <= 1'b0;

        while (sb.exp_status.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
